@@ hdl/fdf_pkg.sv @@
// package: types, constants and cordic table for the fingertip defect filter
`timescale 1ns / 1ps
package fdf_pkg;
  localparam int COORD_BITS      = 12;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ZFRAC           = 20;
  localparam int CORDIC_STEPS    = 20;
  localparam int STEP_BITS       = 5;
  // cordic working width: values normalised to 2^40, growth below 2^43
  localparam int CW              = 44;
  localparam int ZW              = 30;
  localparam int VEC_BITS        = 2 * COORD_BITS + 3;
  localparam int ANG_BITS        = ANGLE_FRAC_BITS + 10;

  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COORD_BITS-1:0] far_x;
    logic [COORD_BITS-1:0] far_y;
    logic [COORD_BITS-1:0] hand_center_x;
    logic [COORD_BITS-1:0] hand_center_y;
    logic [COORD_BITS-1:0] hand_height;
    logic                  first_of_frame;
  } in_word_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] tip_x;
    logic [COORD_BITS-1:0] tip_y;
    logic                  rule_hit;
    logic                  last_of_item;
  } out_word_t;

  typedef struct packed {
    logic load;      // capture input word, form the direction vector
    logic prep_inner;// form dot/cross vectors
    logic start_cd;  // start cordic on current vector
    logic save_dir;  // store cordic result as direction angle
    logic save_inner;
    logic decide;    // evaluate rules
    logic commit;    // update stored tip
  } fdf_cmd_t;

  typedef struct packed {
    logic cd_busy;
    logic rule_a;
    logic rule_b;
  } fdf_sts_t;

  function automatic logic [ZW-1:0] atan_entry(input logic [STEP_BITS-1:0] i);
    case (i)
      5'd0:  atan_entry = ZW'(47185920);
      5'd1:  atan_entry = ZW'(27855475);
      5'd2:  atan_entry = ZW'(14718068);
      5'd3:  atan_entry = ZW'(7471121);
      5'd4:  atan_entry = ZW'(3750058);
      5'd5:  atan_entry = ZW'(1876857);
      5'd6:  atan_entry = ZW'(938658);
      5'd7:  atan_entry = ZW'(469357);
      5'd8:  atan_entry = ZW'(234682);
      5'd9:  atan_entry = ZW'(117342);
      5'd10: atan_entry = ZW'(58671);
      5'd11: atan_entry = ZW'(29335);
      5'd12: atan_entry = ZW'(14668);
      5'd13: atan_entry = ZW'(7334);
      5'd14: atan_entry = ZW'(3667);
      5'd15: atan_entry = ZW'(1833);
      5'd16: atan_entry = ZW'(917);
      5'd17: atan_entry = ZW'(458);
      5'd18: atan_entry = ZW'(229);
      5'd19: atan_entry = ZW'(115);
      default: atan_entry = '0;
    endcase
  endfunction
endpackage

@@ hdl/fdf_cordic.sv @@
// iterative vectoring cordic: atan2 in fixed-point degrees
`timescale 1ns / 1ps
module fdf_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [fdf_pkg::VEC_BITS-1:0] vx,
  input  logic signed [fdf_pkg::VEC_BITS-1:0] vy,
  output logic                                busy,
  output logic signed [fdf_pkg::ANG_BITS-1:0] angle
);
  import fdf_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ITER = 2'd2;
  localparam logic [1:0] C_DONE = 2'd3;

  logic [1:0]            state;
  logic [STEP_BITS-1:0]  step;
  logic signed [CW-1:0]  x, y;
  logic signed [ZW:0]    z;
  logic                  neg_x, neg_y, trivial;
  logic signed [ZW:0]    trivial_z;
  logic signed [CW-1:0]  dx, dy;
  logic signed [ZW:0]    zc, full;
  logic [ZW:0]           mag;
  logic [VEC_BITS-1:0]   ax, ay;

  localparam logic signed [ZW:0] Z90  = (ZW+1)'(90 <<< ZFRAC);
  localparam logic signed [ZW:0] Z180 = (ZW+1)'(180 <<< ZFRAC);
  localparam logic signed [CW-1:0] NLIM = CW'(64'sd1 <<< 40);

  assign ax = vx[VEC_BITS-1] ? VEC_BITS'(-vx) : vx;
  assign ay = vy[VEC_BITS-1] ? VEC_BITS'(-vy) : vy;
  assign dx = y >>> step;
  assign dy = x >>> step;
  assign busy = (state != C_IDLE);

  always_comb begin
    zc = trivial ? trivial_z : z;
    if (zc < 0) zc = '0;
    if (zc > Z90) zc = Z90;
    full = neg_x ? Z180 - zc : zc;
    mag = (ZW+1)'((full + (ZW+1)'(1 <<< (ZFRAC - ANGLE_FRAC_BITS - 1)))
          >>> (ZFRAC - ANGLE_FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      case (state)
        C_IDLE: begin
          if (start) begin
            // a zero vector has a clear sign bit, so it never mirrors
            neg_x <= vx[VEC_BITS-1];
            neg_y <= vy[VEC_BITS-1];
            x <= CW'(ax);
            y <= CW'(ay);
            z <= '0;
            step <= '0;
            if (ax == 0 && ay == 0) begin
              trivial <= 1'b1; trivial_z <= '0; state <= C_DONE;
            end else if (ay == 0) begin
              trivial <= 1'b1; trivial_z <= '0; state <= C_DONE;
            end else if (ax == 0) begin
              trivial <= 1'b1; trivial_z <= Z90; state <= C_DONE;
            end else begin
              trivial <= 1'b0; state <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (x < NLIM && y < NLIM) begin
            x <= x <<< 1;
            y <= y <<< 1;
          end else begin
            state <= C_ITER;
          end
        end
        C_ITER: begin
          if (y > 0) begin
            x <= x + dx; y <= y - dy; z <= z + (ZW+1)'(atan_entry(step));
          end else begin
            x <= x - dx; y <= y + dy; z <= z - (ZW+1)'(atan_entry(step));
          end
          if (step == STEP_BITS'(CORDIC_STEPS - 1)) state <= C_DONE;
          step <= step + 1'b1;
        end
        C_DONE: begin
          angle <= neg_y ? -ANG_BITS'(mag) : ANG_BITS'(mag);
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/fdf_datapath.sv @@
// datapath: vectors, squared lengths, rule tests and stored tip
`timescale 1ns / 1ps
module fdf_datapath (
  input  logic             clk,
  input  logic             rst,
  input  fdf_pkg::in_word_t in_word,
  input  fdf_pkg::fdf_cmd_t cmd,
  output fdf_pkg::fdf_sts_t sts,
  output logic [fdf_pkg::COORD_BITS-1:0] tip_x,
  output logic [fdf_pkg::COORD_BITS-1:0] tip_y
);
  import fdf_pkg::*;

  localparam int SW = COORD_BITS + 1;
  localparam int DW = 2 * COORD_BITS + 2;
  localparam int LW = 2 * COORD_BITS + 8;

  in_word_t                  w;
  logic [COORD_BITS-1:0]     last_x, last_y;
  logic                      have_tip;
  logic signed [VEC_BITS-1:0] vx, vy;
  logic signed [ANG_BITS-1:0] dir_ang, inner_ang, cd_angle;
  logic                      cd_busy;
  logic [DW-1:0]             d1, d2, sp;
  logic signed [SW-1:0]      p1, p2, q1, q2;
  logic                      inner_ok;
  logic signed [SW-1:0]      s1, s2, e1, e2, t1, t2;
  logic signed [VEC_BITS-1:0] dot, crs;
  logic                      ra, rb;

  localparam logic signed [ANG_BITS-1:0] ONE = ANG_BITS'(1 <<< ANGLE_FRAC_BITS);

  fdf_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cmd.start_cd), .vx(vx), .vy(vy),
    .busy(cd_busy), .angle(cd_angle)
  );

  assign s1 = SW'(w.start_x) - SW'(w.far_x);
  assign s2 = SW'(w.start_y) - SW'(w.far_y);
  assign e1 = SW'(w.end_x) - SW'(w.far_x);
  assign e2 = SW'(w.end_y) - SW'(w.far_y);
  assign t1 = SW'(last_x) - SW'(w.start_x);
  assign t2 = SW'(last_y) - SW'(w.start_y);

  assign tip_x = w.start_x;
  assign tip_y = w.start_y;
  assign sts.cd_busy = cd_busy;
  assign sts.rule_a = ra;
  assign sts.rule_b = rb;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_tip <= 1'b0;
      last_x <= '0;
      last_y <= '0;
      ra <= 1'b0;
      rb <= 1'b0;
    end else begin
      if (cmd.load) begin
        w <= in_word;
        if (in_word.first_of_frame) begin
          have_tip <= 1'b0; last_x <= '0; last_y <= '0;
        end
        vx <= VEC_BITS'($signed(SW'(in_word.hand_center_x)) - $signed(SW'(in_word.start_x)));
        vy <= VEC_BITS'($signed(SW'(in_word.hand_center_y)) - $signed(SW'(in_word.start_y)));
      end
      // squared lengths, registered from the captured word
      d1 <= DW'(s1 * s1) + DW'(s2 * s2);
      d2 <= DW'(e1 * e1) + DW'(e2 * e2);
      sp <= DW'(t1 * t1) + DW'(t2 * t2);
      if (cmd.prep_inner) begin
        if (d1 < d2) begin
          q1 <= SW'(w.far_x) - SW'(w.end_x);   q2 <= SW'(w.far_y) - SW'(w.end_y);
          p1 <= SW'(w.start_x) - SW'(w.end_x); p2 <= SW'(w.start_y) - SW'(w.end_y);
        end else begin
          q1 <= SW'(w.far_x) - SW'(w.start_x); q2 <= SW'(w.far_y) - SW'(w.start_y);
          p1 <= SW'(w.end_x) - SW'(w.start_x); p2 <= SW'(w.end_y) - SW'(w.start_y);
        end
      end
      // products registered before the cordic load
      dot <= VEC_BITS'(p1 * q1) + VEC_BITS'(p2 * q2);
      crs <= VEC_BITS'(p1 * q2) - VEC_BITS'(p2 * q1);
      inner_ok <= (p1 != 0 || p2 != 0) && (q1 != 0 || q2 != 0);
      if (cmd.save_dir) begin
        dir_ang <= cd_angle;
        vx <= dot;
        vy <= crs[VEC_BITS-1] ? -crs : crs;
      end
      if (cmd.save_inner) inner_ang <= cd_angle;
      if (cmd.decide) begin
        ra <= dir_ang > 0 && dir_ang < ANG_BITS'(179) * ONE && inner_ok &&
              inner_ang > ANG_BITS'(20) * ONE && inner_ang < ANG_BITS'(80) * ONE &&
              LW'(d1) * LW'(100) > LW'(w.hand_height) * LW'(w.hand_height) &&
              (!have_tip || sp > DW'(1000));
        rb <= dir_ang > -(ANG_BITS'(30) * ONE) && dir_ang < ANG_BITS'(30) * ONE &&
              inner_ok && inner_ang < ANG_BITS'(30) * ONE &&
              have_tip && sp > DW'(1000);
      end
      if (cmd.commit) begin
        last_x <= w.start_x; last_y <= w.start_y; have_tip <= 1'b1;
      end
    end
  end
endmodule

@@ hdl/fdf_ctrl.sv @@
// controller: sequences one defect through the cordic and output words
`timescale 1ns / 1ps
module fdf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  fdf_pkg::fdf_sts_t sts,
  output fdf_pkg::fdf_cmd_t cmd,
  output logic              rule_hit,
  output logic              last_of_item
);
  import fdf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_DIR   = 4'd2;
  localparam logic [3:0] S_DIRW  = 4'd3;
  localparam logic [3:0] S_INNER = 4'd4;
  localparam logic [3:0] S_INW   = 4'd5;
  localparam logic [3:0] S_DEC   = 4'd6;
  localparam logic [3:0] S_EVAL  = 4'd7;
  localparam logic [3:0] S_OUTA  = 4'd8;
  localparam logic [3:0] S_OUTB  = 4'd9;

  logic [3:0] state, state_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUTA) || (state == S_OUTB);
  assign rule_hit  = (state == S_OUTB);
  assign last_of_item = (state == S_OUTB) || !sts.rule_b;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; state_next = S_PREP; end
      // squared lengths settle here
      S_PREP: state_next = S_DIR;
      S_DIR:  begin cmd.prep_inner = 1'b1; cmd.start_cd = 1'b1; state_next = S_DIRW; end
      S_DIRW: if (!sts.cd_busy) begin cmd.save_dir = 1'b1; state_next = S_INNER; end
      S_INNER: begin cmd.start_cd = 1'b1; state_next = S_INW; end
      S_INW:  if (!sts.cd_busy) begin cmd.save_inner = 1'b1; state_next = S_DEC; end
      S_DEC:  begin cmd.decide = 1'b1; state_next = S_EVAL; end
      S_EVAL: begin
        if (sts.rule_a || sts.rule_b) cmd.commit = 1'b1;
        if (sts.rule_a)      state_next = S_OUTA;
        else if (sts.rule_b) state_next = S_OUTB;
        else                 state_next = S_IDLE;
      end
      S_OUTA: if (!out_stall) state_next = sts.rule_b ? S_OUTB : S_IDLE;
      S_OUTB: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end
endmodule

@@ hdl/fingertip_defect_filter_unit.sv @@
// top level: fingertip defect filter, controller plus datapath
// each accepted word makes two cordic passes: an axis or zero vector skips the
// iterations, any other takes up to 40 normalising shifts and then 20 steps
// the next word is taken only once the previous one and its result words are done
// reset: synchronous active-high rst clears the stored tip and the controller
`timescale 1ns / 1ps
module fingertip_defect_filter_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  fdf_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fdf_pkg::out_word_t out_data
);
  import fdf_pkg::*;

  fdf_cmd_t cmd;
  fdf_sts_t sts;
  logic [COORD_BITS-1:0] tx, ty;
  logic rh, lo;

  // sequencer: handshakes and command strobes
  fdf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd),
    .rule_hit(rh), .last_of_item(lo)
  );

  // arithmetic and stored tip
  fdf_datapath u_dp (
    .clk(clk), .rst(rst), .in_word(in_data), .cmd(cmd), .sts(sts),
    .tip_x(tx), .tip_y(ty)
  );

  // result word built from the held candidate point
  assign out_data.tip_x = tx;
  assign out_data.tip_y = ty;
  assign out_data.rule_hit = rh;
  assign out_data.last_of_item = lo;

`ifndef SYNTHESIS
  // no word accepted while a result is being offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken during output");
  // a rule a result that is not last is followed by a rule b word
  a_pair: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_data.last_of_item) |=>
      (out_valid && out_data.rule_hit)) else $error("pair broken");
  // a rule b word is always the last of its item
  a_b_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.rule_hit) |-> out_data.last_of_item)
    else $error("rule b not last");
`endif
endmodule
